// File: rtl/s39m_pkg.sv
// Shared types and constants of the Sv39 page-table mapper.
package s39m_pkg;

	localparam int VA_W      = 39;
	localparam int PA_W      = 56;
	localparam int PPN_W     = 44;
	localparam int VPN_W     = 27;
	localparam int IDX_W     = 9;
	localparam int PAGE_SH   = 12;
	localparam int COUNT_W   = 13;
	localparam int PERM_W    = 3;
	localparam int USED_W    = 7;
	localparam int ENTRY_W   = 54;
	localparam int MAX_PAGES = 4096;

	typedef struct packed {
		logic [VA_W-1:0]    virt_addr;
		logic [PA_W-1:0]    phys_addr;
		logic [COUNT_W-1:0] page_count;
		logic [PERM_W-1:0]  perm;
	} req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] pages_mapped;
		logic [USED_W-1:0]  tables_used;
		logic               pool_full;
	} rsp_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD1,
		ST_CK1,
		ST_AL1,
		ST_RD2,
		ST_CK2,
		ST_AL2,
		ST_LEAF,
		ST_DONE
	} state_t;

endpackage

// File: rtl/s39m_addsub.sv
// Shared page-number adder/subtractor used for pointer checks and table allocation.
module s39m_addsub
	import s39m_pkg::*;
(
	input  logic [PPN_W-1:0] a,
	input  logic [PPN_W-1:0] b,
	input  logic             sub,
	output logic [PPN_W-1:0] y
);

	logic [PPN_W-1:0] b_inv;

	assign b_inv = b ^ {PPN_W{sub}};
	assign y     = a + b_inv + PPN_W'(sub);

endmodule

// File: rtl/s39m_store.sv
// Single-port table store holding every page-table entry of the pool.
module s39m_store
	import s39m_pkg::*;
#(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic               clk,
	input  mem_cmd_t           cmd,
	input  logic [AW-1:0]      addr,
	input  logic [ENTRY_W-1:0] wdata,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/s39m_ctrl.sv
// Walk sequencer: clearing pass, table lookups, allocation and leaf writes.
module s39m_ctrl
	import s39m_pkg::*;
#(
	parameter int MAX_TABLES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  req_t                              in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output rsp_t                              out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [PPN_W-1:0]                  cfg_data,
	output mem_cmd_t                          mem_cmd,
	output logic [$clog2(MAX_TABLES)+IDX_W-1:0] mem_addr,
	output logic [ENTRY_W-1:0]                mem_wdata,
	input  logic [ENTRY_W-1:0]                mem_rdata
);

	localparam int TW    = $clog2(MAX_TABLES);
	localparam int AW    = TW + IDX_W;
	localparam int CW    = $clog2(MAX_TABLES + 1);
	localparam int DEPTH = MAX_TABLES * (1 << IDX_W);

	state_t state_q, state_d;

	logic [AW-1:0]      clr_q;
	logic [PPN_W-1:0]   base_q;
	logic [CW-1:0]      alloc_q;
	logic [VPN_W-1:0]   va_pg_q;
	logic [PPN_W-1:0]   pa_pg_q;
	logic [PERM_W-1:0]  perm_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] done_q;
	logic               full_q;
	logic [TW-1:0]      t_q;
	logic               out_valid_q;
	rsp_t               out_data_q;

	logic [PPN_W-1:0]   unit_a, unit_b, unit_y;
	logic               unit_sub;
	logic [IDX_W-1:0]   i1, i2, i3;
	logic [TW-1:0]      y_idx;
	logic [PPN_W-1:0]   alloc_ext;
	logic [COUNT_W:0]   alloc_wide;
	logic [COUNT_W-1:0] done_nxt;
	logic [COUNT_W-1:0] count_sat;
	logic [ENTRY_W-1:0] ptr_entry, leaf_entry;
	logic               hit, pool_ok, last_page, out_free, clr_last;

	s39m_addsub u_addsub (
		.a   (unit_a),
		.b   (unit_b),
		.sub (unit_sub),
		.y   (unit_y)
	);

	assign i1 = va_pg_q[3*IDX_W-1:2*IDX_W];
	assign i2 = va_pg_q[2*IDX_W-1:IDX_W];
	assign i3 = va_pg_q[IDX_W-1:0];

	assign alloc_ext  = PPN_W'(alloc_q);
	assign alloc_wide = (COUNT_W+1)'(alloc_q);
	assign y_idx      = unit_y[TW-1:0];
	// A pointer counts only if it is valid and names a table already handed out.
	assign hit        = mem_rdata[0] && (unit_y < alloc_ext);
	assign pool_ok    = alloc_q < CW'(MAX_TABLES);
	assign done_nxt   = done_q + COUNT_W'(1);
	assign last_page  = done_nxt == count_q;
	assign out_free   = !out_valid_q || !out_stall;
	assign clr_last   = clr_q == AW'(DEPTH - 1);
	assign count_sat  = (in_data.page_count > COUNT_W'(MAX_PAGES)) ?
		COUNT_W'(MAX_PAGES) : in_data.page_count;

	assign ptr_entry  = {unit_y, {(IDX_W){1'b0}}, 1'b1};
	assign leaf_entry = {pa_pg_q, {(IDX_W-PERM_W){1'b0}}, perm_q, 1'b1};

	// Shared unit: subtract the pool base while checking, add it while allocating.
	always_comb begin
		unit_sub = 1'b1;
		unit_a   = mem_rdata[ENTRY_W-1:IDX_W+1];
		unit_b   = base_q;
		if (state_q == ST_AL1 || state_q == ST_AL2) begin
			unit_sub = 1'b0;
			unit_a   = base_q;
			unit_b   = alloc_ext;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (count_sat == '0) ? ST_DONE : ST_RD1;
				end
			end
			ST_RD1: state_d = ST_CK1;
			ST_CK1: begin
				if (hit)          state_d = ST_CK2;
				else if (pool_ok) state_d = ST_AL1;
				else              state_d = ST_DONE;
			end
			ST_AL1: state_d = ST_RD2;
			ST_RD2: state_d = ST_CK2;
			ST_CK2: begin
				if (hit)          state_d = last_page ? ST_DONE : ST_RD1;
				else if (pool_ok) state_d = ST_AL2;
				else              state_d = ST_DONE;
			end
			ST_AL2: state_d = ST_LEAF;
			ST_LEAF: state_d = last_page ? ST_DONE : ST_RD1;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		mem_cmd   = '0;
		mem_addr  = '0;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_cmd.wr = 1'b1;
				mem_addr   = clr_q;
			end
			ST_RD1: begin
				mem_cmd.rd = 1'b1;
				mem_addr   = {{TW{1'b0}}, i1};
			end
			ST_CK1: begin
				// On a hit the level-two read goes out straight away.
				if (hit) begin
					mem_cmd.rd = 1'b1;
					mem_addr   = {y_idx, i2};
				end
			end
			ST_AL1: begin
				mem_cmd.wr = 1'b1;
				mem_addr   = {{TW{1'b0}}, i1};
				mem_wdata  = ptr_entry;
			end
			ST_RD2: begin
				mem_cmd.rd = 1'b1;
				mem_addr   = {t_q, i2};
			end
			ST_CK2: begin
				if (hit) begin
					mem_cmd.wr = 1'b1;
					mem_addr   = {y_idx, i3};
					mem_wdata  = leaf_entry;
				end
			end
			ST_AL2: begin
				mem_cmd.wr = 1'b1;
				mem_addr   = {t_q, i2};
				mem_wdata  = ptr_entry;
			end
			ST_LEAF: begin
				mem_cmd.wr = 1'b1;
				mem_addr   = {t_q, i3};
				mem_wdata  = leaf_entry;
			end
			default: begin
				mem_cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			base_q      <= '0;
			alloc_q     <= CW'(1);
			done_q      <= '0;
			count_q     <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				base_q <= cfg_data;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_IDLE: begin
					if (in_valid) begin
						count_q <= count_sat;
						done_q  <= '0;
						full_q  <= 1'b0;
					end
				end
				ST_CK1, ST_CK2: begin
					if (!hit && !pool_ok) full_q <= 1'b1;
					if (state_q == ST_CK2 && hit) done_q <= done_nxt;
				end
				ST_AL1, ST_AL2: alloc_q <= alloc_q + CW'(1);
				ST_LEAF: done_q <= done_nxt;
				default: begin
					full_q <= full_q;
				end
			endcase
		end
	end

	// Payload registers of the walk and of the result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					va_pg_q <= in_data.virt_addr[VA_W-1:PAGE_SH];
					pa_pg_q <= in_data.phys_addr[PA_W-1:PAGE_SH];
					perm_q  <= in_data.perm;
				end
			end
			ST_CK1: begin
				if (hit) t_q <= y_idx;
			end
			ST_AL1, ST_AL2: t_q <= alloc_q[TW-1:0];
			ST_CK2, ST_LEAF: begin
				if (state_q == ST_LEAF || hit) begin
					va_pg_q <= va_pg_q + VPN_W'(1);
					pa_pg_q <= pa_pg_q + PPN_W'(1);
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_data_q.pages_mapped <= done_q;
					out_data_q.tables_used  <= alloc_wide[USED_W-1:0];
					out_data_q.pool_full    <= full_q;
				end
			end
			default: begin
				perm_q <= perm_q;
			end
		endcase
	end

	assign in_stall  = state_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/sv39_page_table_mapper_core.sv
// Top level of the Sv39 page-table mapper: sequencer plus on-chip table store.
// After reset the block runs a clearing pass over the whole table store (MAX_TABLES * 512
// entries), during which no request is taken; the pool base register can be written at any
// time the block is idle. A request maps page_count 4 KiB pages (saturated at 4096); its
// walk is paced by the single-port table store, which serves one read or one write per
// cycle, and by the one shared page-number adder that checks and allocates table pointers.
// A new request is taken only once the previous one has finished and its result has been
// registered for output; that result waits in its register until transferred.
module sv39_page_table_mapper_core
	import s39m_pkg::*;
#(
	parameter int MAX_TABLES = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  req_t             in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output rsp_t             out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [PPN_W-1:0] cfg_data
);

	localparam int AW    = $clog2(MAX_TABLES) + IDX_W;
	localparam int DEPTH = MAX_TABLES * (1 << IDX_W);

	mem_cmd_t           mem_cmd;
	logic [AW-1:0]      mem_addr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [ENTRY_W-1:0] mem_rdata;

	s39m_ctrl #(
		.MAX_TABLES (MAX_TABLES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.mem_cmd   (mem_cmd),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	s39m_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.cmd   (mem_cmd),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule
